FILE: sv/lnfb_pkg.sv
// Shared types, constants and saturating helpers for the layer norm block.
`default_nettype none
package lnfb_pkg;

	localparam int LR_W = 25;
	localparam logic [LR_W-1:0] LR_RESET = 25'd167772;
	localparam logic signed [31:0] Q_ONE = 32'sd16777216;
	localparam logic [32:0] EPS_Q = 33'd17;
	localparam logic signed [63:0] WMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] HALF_NEG = -64'sd8388608;
	localparam logic signed [63:0] TWO_P48 = 64'sh0001_0000_0000_0000;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV,
		OP_SQRT
	} lnfb_op_t;

	typedef struct packed {
		logic start;
		lnfb_op_t op;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} lnfb_ar_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] res;
	} lnfb_ar_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		F_SUM_RD, F_SUM_ACC, F_MEAN, F_SQ_RD, F_SQ_MUL, F_VAR,
		ST_STD,
		F_OUT_RD, F_NORM, F_SCALE, F_EMIT,
		B_INV, B_P1, B_P2,
		B_A_RD, B_A_DXH, B_A_T1, B_A_T2, B_A_T3, B_A_G1, B_A_G2,
		B_DM0, B_DM1,
		B_B_RD, B_B_DXH, B_B_M,
		B_DMN,
		B_C_RD, B_C_DXH, B_C_V0, B_C_V1, B_C_V2, B_C_EMIT,
		B_UB1, B_UB2, B_UG1, B_UG2
	} lnfb_state_t;

	function automatic logic signed [63:0] clampw(input logic signed [63:0] v);
		if (v > WMAX) begin
			return WMAX;
		end else if (v < -WMAX) begin
			return -WMAX;
		end
		return v;
	endfunction

	function automatic logic signed [63:0] addw(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = clampw(a) + clampw(b);
		return clampw(s);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: sv/lnfb_arith.sv
// Shared multi-cycle unit: Q.24 saturating multiply, signed divide, integer square root.
`default_nettype none
module lnfb_arith import lnfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lnfb_ar_req_t req,
	output lnfb_ar_rsp_t rsp
);

	localparam logic [5:0] MUL_LAST = 6'd3;
	localparam logic [5:0] DIV_LAST = 6'd63;
	localparam logic [5:0] SQRT_LAST = 6'd31;

	logic busy_q, fin_q, done_q, neg_q;
	lnfb_op_t op_q;
	logic [5:0] cnt_q;
	logic [63:0] x_q, y_q;
	logic [64:0] z_q;
	logic [123:0] acc_q;
	logic signed [63:0] res_q;

	logic signed [63:0] ca, cb, aa, ab;
	logic [30:0] pa, pb;
	logic [61:0] pp;
	logic [6:0] sh;
	logic [123:0] acc_d;
	logic [64:0] rsh;
	logic ge;
	logic [63:0] st;
	logic sge;
	logic [63:0] mag;
	logic signed [63:0] fin_val;
	logic [5:0] last_cnt;
	logic step;

	always_comb begin
		ca = clampw(req.a);
		cb = clampw(req.b);
		if (req.op == OP_MUL) begin
			aa = ca[63] ? -ca : ca;
			ab = cb[63] ? -cb : cb;
		end else begin
			aa = req.a[63] ? -req.a : req.a;
			ab = req.b[63] ? -req.b : req.b;
		end
		pa = cnt_q[1] ? x_q[61:31] : x_q[30:0];
		pb = cnt_q[0] ? y_q[61:31] : y_q[30:0];
		pp = pa * pb;
		sh = (cnt_q[1] & cnt_q[0]) ? 7'd62 : ((cnt_q[1] | cnt_q[0]) ? 7'd31 : 7'd0);
		acc_d = acc_q + ({62'd0, pp} << sh);
		rsh = {z_q[63:0], x_q[63]};
		ge = rsh >= {1'b0, y_q};
		st = x_q + y_q;
		sge = z_q[63:0] >= st;
		mag = (|acc_q[123:86]) ? WMAX : {2'b00, acc_q[85:24]};
		case (op_q)
			OP_MUL:  fin_val = neg_q ? -$signed(mag) : $signed(mag);
			OP_DIV:  fin_val = neg_q ? -$signed(x_q) : $signed(x_q);
			OP_SQRT: fin_val = $signed(x_q);
			default: fin_val = '0;
		endcase
		case (op_q)
			OP_MUL:  last_cnt = MUL_LAST;
			OP_DIV:  last_cnt = DIV_LAST;
			default: last_cnt = SQRT_LAST;
		endcase
		step = busy_q && !fin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_cnt) begin
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q <= 1'b0;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q <= req.op;
			case (req.op)
				OP_MUL: begin
					neg_q <= ca[63] ^ cb[63];
					x_q <= aa;
					y_q <= ab;
					acc_q <= '0;
				end
				OP_DIV: begin
					neg_q <= req.a[63] ^ req.b[63];
					x_q <= aa;
					y_q <= ab;
					z_q <= '0;
				end
				default: begin
					neg_q <= 1'b0;
					x_q <= '0;
					y_q <= 64'h4000_0000_0000_0000;
					z_q <= {1'b0, req.a};
				end
			endcase
		end else if (step) begin
			case (op_q)
				OP_MUL: acc_q <= acc_d;
				OP_DIV: begin
					if (ge) begin
						z_q <= rsh - {1'b0, y_q};
						x_q <= {x_q[62:0], 1'b1};
					end else begin
						z_q <= rsh;
						x_q <= {x_q[62:0], 1'b0};
					end
				end
				default: begin
					if (sge) begin
						z_q <= {1'b0, z_q[63:0] - st};
						x_q <= (x_q >> 1) + y_q;
					end else begin
						x_q <= x_q >> 1;
					end
					y_q <= y_q >> 2;
				end
			endcase
		end else if (fin_q) begin
			res_q <= fin_val;
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule
`default_nettype wire

FILE: sv/layer_norm_forward_backward.sv
// Layer normalization with learnable gamma/beta, forward and backward, signed Q8.24.
// Input stream: s_tdata carries one value per beat, s_tuser selects forward node
// value (0) or backward delta (1), s_tlast closes the vector. Non-last beats are
// stored and taken one per cycle. On the last beat the block runs its vector pass
// and emits one result beat per node on the m_ side, m_tlast on the final one.
// Forward: each result needs a 64-step divide and a multiply per node, after the
// mean, variance and standard deviation are found. Backward: the pass emits one
// output beat per node, then gamma and beta are updated. Every pass is a series of
// multiply, divide and square root operations on one shared iterative unit, over
// values read back from the two node memories. s_tready is low while a pass runs.
// A stalled m_ side holds the pass at the next result; the final result waits in
// the output register while new input beats are taken. cfg_we writes the learning
// rate (unsigned Q1.24); the user must do so only when idle, which the block does
// not enforce. Reset clears the control state, mean and variance, beta to 0,
// gamma to 1.0 and the learning rate to its default; the memories are not cleared.
`default_nettype none
module layer_norm_forward_backward import lnfb_pkg::*; #(
	parameter int MAX_NODES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [LR_W-1:0] cfg_wdata,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [31:0]     s_tdata,  // value
	input  logic            s_tuser,  // action
	input  logic            s_tlast,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [31:0]     m_tdata,  // result_value
	output logic            m_tlast
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = 33 + CW;
	localparam int SQW = 40 + CW;
	localparam int DMW = 34 + CW;
	localparam int DBW = 32 + CW;
	localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);

	logic [31:0] saved_mem [MAX_NODES];
	logic [31:0] delta_mem [MAX_NODES];

	lnfb_state_t state_q, state_d;
	logic bwd_q, wait_q;
	logic [CW-1:0] idx_q, n_q, load_index_q, ld_next;
	logic [LR_W-1:0] lr_q;
	logic signed [31:0] mean_q, beta_q, gamma_q;
	logic [31:0] var_q, sd_q;
	logic [31:0] x_rd_q, d_rd_q;
	logic signed [SW-1:0] sum_q;
	logic [SQW-1:0] sumsq_q;
	logic signed [DMW-1:0] dm1_q;
	logic signed [DBW-1:0] dbeta_q;
	logic signed [63:0] is_q, p_q, t_q, v_q, dvar_q, dgamma_q, dmean_q, dmn_q;
	logic m_tvalid_q, m_tlast_q;
	logic [31:0] m_tdata_q;

	lnfb_ar_req_t req;
	lnfb_ar_rsp_t rsp;

	logic s_acc, ld_room, done, at_end, out_free;
	logic op_act, rd_en, out_load, out_last;
	logic signed [31:0] out_val;
	lnfb_op_t op_sel;
	logic signed [63:0] a_sel, b_sel;
	logic signed [32:0] c_w;
	logic signed [63:0] c64, x_ext, d64, g64, beta64, n64, dv2;
	logic [32:0] ve;

	lnfb_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		s_acc = s_tvalid && s_tready;
		ld_room = load_index_q != MAXC;
		ld_next = ld_room ? load_index_q + CW'(1) : load_index_q;
		done = rsp.done;
		at_end = (idx_q + CW'(1)) == n_q;
		out_free = !m_tvalid_q || m_tready;
		x_ext = {{32{x_rd_q[31]}}, x_rd_q};
		c_w = $signed({x_rd_q[31], x_rd_q}) - $signed({mean_q[31], mean_q});
		c64 = {{31{c_w[32]}}, c_w};
		d64 = {{32{d_rd_q[31]}}, d_rd_q};
		g64 = {{32{gamma_q[31]}}, gamma_q};
		beta64 = {{32{beta_q[31]}}, beta_q};
		n64 = {{(64 - CW){1'b0}}, n_q};
		dv2 = clampw({dvar_q[62:0], 1'b0});
		ve = {1'b0, var_q} + EPS_Q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tlast) begin
					state_d = s_tuser ? ST_STD : F_SUM_RD;
				end
			end
			F_SUM_RD:  state_d = F_SUM_ACC;
			F_SUM_ACC: state_d = at_end ? F_MEAN : F_SUM_RD;
			F_MEAN:    if (done) state_d = F_SQ_RD;
			F_SQ_RD:   state_d = F_SQ_MUL;
			F_SQ_MUL:  if (done) state_d = at_end ? F_VAR : F_SQ_RD;
			F_VAR:     if (done) state_d = ST_STD;
			ST_STD:    if (done) state_d = bwd_q ? B_INV : F_OUT_RD;
			F_OUT_RD:  state_d = F_NORM;
			F_NORM:    if (done) state_d = F_SCALE;
			F_SCALE:   if (done) state_d = F_EMIT;
			F_EMIT:    if (out_free) state_d = at_end ? ST_IDLE : F_OUT_RD;
			B_INV:     if (done) state_d = B_P1;
			B_P1:      if (done) state_d = B_P2;
			B_P2:      if (done) state_d = B_A_RD;
			B_A_RD:    state_d = B_A_DXH;
			B_A_DXH:   if (done) state_d = B_A_T1;
			B_A_T1:    if (done) state_d = B_A_T2;
			B_A_T2:    if (done) state_d = B_A_T3;
			B_A_T3:    if (done) state_d = B_A_G1;
			B_A_G1:    if (done) state_d = B_A_G2;
			B_A_G2:    if (done) state_d = at_end ? B_DM0 : B_A_RD;
			B_DM0:     if (done) state_d = B_DM1;
			B_DM1:     if (done) state_d = B_B_RD;
			B_B_RD:    state_d = B_B_DXH;
			B_B_DXH:   if (done) state_d = B_B_M;
			B_B_M:     if (done) state_d = at_end ? B_DMN : B_B_RD;
			B_DMN:     if (done) state_d = B_C_RD;
			B_C_RD:    state_d = B_C_DXH;
			B_C_DXH:   if (done) state_d = B_C_V0;
			B_C_V0:    if (done) state_d = B_C_V1;
			B_C_V1:    if (done) state_d = B_C_V2;
			B_C_V2:    if (done) state_d = B_C_EMIT;
			B_C_EMIT:  if (out_free) state_d = at_end ? B_UB1 : B_C_RD;
			B_UB1:     if (done) state_d = B_UB2;
			B_UB2:     if (done) state_d = B_UG1;
			B_UG1:     if (done) state_d = B_UG2;
			B_UG2:     if (done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op_act = 1'b1;
		op_sel = OP_MUL;
		a_sel = '0;
		b_sel = '0;
		rd_en = 1'b0;
		out_load = 1'b0;
		out_val = '0;
		out_last = at_end;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				op_act = 1'b0;
				s_tready = 1'b1;
			end
			F_SUM_RD, F_SQ_RD, F_OUT_RD, B_A_RD, B_B_RD, B_C_RD: begin
				op_act = 1'b0;
				rd_en = 1'b1;
			end
			F_SUM_ACC: op_act = 1'b0;
			F_MEAN: begin
				op_sel = OP_DIV;
				a_sel = {{(64 - SW){sum_q[SW-1]}}, sum_q};
				b_sel = n64;
			end
			F_SQ_MUL: begin
				a_sel = c64;
				b_sel = c64;
			end
			F_VAR: begin
				op_sel = OP_DIV;
				a_sel = {{(64 - SQW){1'b0}}, sumsq_q};
				b_sel = n64;
			end
			ST_STD: begin
				op_sel = OP_SQRT;
				a_sel = {7'd0, ve, 24'd0};
			end
			F_NORM: begin
				op_sel = OP_DIV;
				a_sel = {c64[39:0], 24'd0};
				b_sel = {32'd0, sd_q};
			end
			F_SCALE: begin
				a_sel = g64;
				b_sel = t_q;
			end
			F_EMIT: begin
				op_act = 1'b0;
				out_load = out_free;
				out_val = sat32(addw(t_q, beta64));
			end
			B_INV: begin
				op_sel = OP_DIV;
				a_sel = TWO_P48;
				b_sel = {32'd0, sd_q};
			end
			B_P1: begin
				a_sel = is_q;
				b_sel = is_q;
			end
			B_P2, B_A_G2, B_B_M, B_C_V0: begin
				a_sel = t_q;
				b_sel = is_q;
			end
			B_A_DXH, B_B_DXH, B_C_DXH: begin
				a_sel = d64;
				b_sel = g64;
			end
			B_A_T1: begin
				a_sel = t_q;
				b_sel = c64;
			end
			B_A_T2: begin
				a_sel = t_q;
				b_sel = HALF_NEG;
			end
			B_A_T3: begin
				a_sel = t_q;
				b_sel = p_q;
			end
			B_A_G1: begin
				a_sel = d64;
				b_sel = c64;
			end
			B_DM0: begin
				op_sel = OP_DIV;
				a_sel = dvar_q;
				b_sel = n64;
			end
			B_DM1: begin
				a_sel = {{(64 - DMW){dm1_q[DMW-1]}}, dm1_q};
				b_sel = t_q;
			end
			B_DMN: begin
				op_sel = OP_DIV;
				a_sel = dmean_q;
				b_sel = n64;
			end
			B_C_V1: begin
				a_sel = dv2;
				b_sel = c64;
			end
			B_C_V2, B_UB2, B_UG2: begin
				op_sel = OP_DIV;
				a_sel = t_q;
				b_sel = n64;
			end
			B_C_EMIT: begin
				op_act = 1'b0;
				out_load = out_free;
				out_val = sat32(addw(v_q, dmn_q));
			end
			B_UB1: begin
				a_sel = {{(64 - LR_W){1'b0}}, lr_q};
				b_sel = {{(64 - DBW){dbeta_q[DBW-1]}}, dbeta_q};
			end
			B_UG1: begin
				a_sel = {{(64 - LR_W){1'b0}}, lr_q};
				b_sel = dgamma_q;
			end
			default: op_act = 1'b0;
		endcase
		req.start = op_act && !wait_q;
		req.op = op_sel;
		req.a = a_sel;
		req.b = b_sel;
	end

	always_ff @(posedge clk) begin
		if (s_acc && ld_room) begin
			if (s_tuser) begin
				delta_mem[load_index_q[AW-1:0]] <= s_tdata;
			end else begin
				saved_mem[load_index_q[AW-1:0]] <= s_tdata;
			end
		end
		if (rd_en) begin
			x_rd_q <= saved_mem[idx_q[AW-1:0]];
			d_rd_q <= delta_mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bwd_q <= 1'b0;
			wait_q <= 1'b0;
			idx_q <= '0;
			n_q <= '0;
			load_index_q <= '0;
			lr_q <= LR_RESET;
			mean_q <= '0;
			var_q <= '0;
			beta_q <= '0;
			gamma_q <= Q_ONE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				lr_q <= cfg_wdata;
			end
			if (req.start) begin
				wait_q <= 1'b1;
			end else if (done) begin
				wait_q <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (s_acc) begin
				if (s_tlast) begin
					load_index_q <= '0;
					n_q <= ld_next;
					bwd_q <= s_tuser;
					idx_q <= '0;
				end else begin
					load_index_q <= ld_next;
				end
			end
			case (state_q)
				F_SUM_ACC: idx_q <= at_end ? '0 : idx_q + CW'(1);
				F_MEAN: if (done) mean_q <= rsp.res[31:0];
				F_SQ_MUL: if (done) idx_q <= at_end ? '0 : idx_q + CW'(1);
				F_VAR: begin
					if (done) begin
						var_q <= (|rsp.res[63:31]) ? 32'h7FFF_FFFF : rsp.res[31:0];
					end
				end
				ST_STD: if (done) idx_q <= '0;
				F_EMIT, B_C_EMIT: if (out_free) idx_q <= at_end ? '0 : idx_q + CW'(1);
				B_A_G2, B_B_M: if (done) idx_q <= at_end ? '0 : idx_q + CW'(1);
				B_UB2: if (done) beta_q <= sat32(beta64 - rsp.res);
				B_UG2: if (done) gamma_q <= sat32(g64 - rsp.res);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_val;
			m_tlast_q <= out_last;
		end
		if (s_acc && s_tlast) begin
			sum_q <= '0;
		end
		case (state_q)
			F_SUM_ACC: sum_q <= sum_q + x_ext[SW-1:0];
			F_MEAN: if (done) sumsq_q <= '0;
			F_SQ_MUL: if (done) sumsq_q <= sumsq_q + rsp.res[SQW-1:0];
			ST_STD: if (done) sd_q <= rsp.res[31:0];
			F_NORM, F_SCALE, B_P1, B_A_T1, B_A_T2, B_A_G1, B_DM0,
			B_B_DXH, B_C_DXH, B_C_V1, B_UB1, B_UG1: begin
				if (done) t_q <= rsp.res;
			end
			B_INV: if (done) is_q <= rsp.res;
			B_P2: begin
				if (done) begin
					p_q <= rsp.res;
					dvar_q <= '0;
					dm1_q <= '0;
					dbeta_q <= '0;
					dgamma_q <= '0;
				end
			end
			B_A_DXH: begin
				if (done) begin
					t_q <= rsp.res;
					dm1_q <= dm1_q - {{(DMW - 34){c_w[32]}}, c_w, 1'b0};
					dbeta_q <= dbeta_q + d64[DBW-1:0];
				end
			end
			B_A_T3: if (done) dvar_q <= addw(dvar_q, rsp.res);
			B_A_G2: if (done) dgamma_q <= addw(dgamma_q, rsp.res);
			B_DM1: if (done) dmean_q <= rsp.res;
			B_B_M: if (done) dmean_q <= addw(dmean_q, -rsp.res);
			B_DMN: if (done) dmn_q <= rsp.res;
			B_C_V0: if (done) v_q <= rsp.res;
			B_C_V2: if (done) v_q <= addw(v_q, rsp.res);
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for layer_norm_forward_backward: random forward/backward vectors vs a built-in predictor.
`default_nettype none
module testbench;
	import lnfb_pkg::*;

	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_BWD = 1'b1;
	localparam int NODES = 16;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 400;
	localparam longint HI_LIM = 64'd274877906943;

	typedef struct {
		logic        act;
		logic [31:0] val;
		logic        last;
	} beat_t;

	typedef struct {
		logic [31:0] val;
		logic        last;
	} norm_out_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [LR_W-1:0] cfg_wdata;
	logic            s_tvalid;
	logic            s_tready;
	logic [31:0]     s_tdata;  // value
	logic            s_tuser;  // action
	logic            s_tlast;
	logic            m_tvalid;
	logic            m_tready;
	logic [31:0]     m_tdata;  // result_value
	logic            m_tlast;

	layer_norm_forward_backward u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// predictor state
	int     node_val[NODES];
	int     delta_val[NODES];
	int     fill_idx;
	int     mean_q;
	int     var_q;
	int     beta_q;
	int     gamma_q;
	longint lrate_q;

	// generator bookkeeping
	bit     x_written[NODES];
	bit     d_written[NODES];
	int     gen_idx;

	beat_t     beat_q[$];
	norm_out_t expected_q[$];
	beat_t     cur_beat;

	int  errors;
	int  beats_in;
	int  results_seen;
	int  lr_writes;
	int  cycles;
	bit  beat_taken;
	int  src_gap;
	int  sink_hold;
	bit  long_hold_done;
	bit  no_idle;

	function automatic longint clip62(longint v);
		if (v > WMAX) return WMAX;
		if (v < -WMAX) return -WMAX;
		return v;
	endfunction

	function automatic longint add62(longint a, longint b);
		return clip62(clip62(a) + clip62(b));
	endfunction

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return int'(v);
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint unsigned ua, ub, ah, al, bh, bl, s;
		bit neg;
		a = clip62(a);
		b = clip62(b);
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		ah = ua >> 24;
		al = ua & 64'hFF_FFFF;
		bh = ub >> 24;
		bl = ub & 64'hFF_FFFF;
		if (ah != 0 && bh > HI_LIM / ah) begin
			s = WMAX;
		end else begin
			s = ((ah * bh) << 24) + ah * bl + al * bh + ((al * bl) >> 24);
			if (s > WMAX) s = WMAX;
		end
		return neg ? -longint'(s) : longint'(s);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned std_dev_q();
		longint unsigned ve;
		ve = (var_q < 0) ? 64'd17 : longint'(var_q) + 64'd17;
		return root_floor(ve << 24);
	endfunction

	task automatic normalize_layer(int n);
		longint sum, c, nm;
		longint unsigned sq, uc, sd, vv;
		norm_out_t r;
		sum = 0;
		sq = 0;
		for (int i = 0; i < n; i++) sum += node_val[i];
		mean_q = int'(sum / longint'(n));
		for (int i = 0; i < n; i++) begin
			c = longint'(node_val[i]) - mean_q;
			uc = (c < 0) ? -c : c;
			sq += (uc * uc) >> 24;
		end
		vv = sq / longint'(n);
		var_q = (vv > 64'd2147483647) ? 32'h7FFF_FFFF : int'(vv);
		sd = std_dev_q();
		for (int i = 0; i < n; i++) begin
			c = longint'(node_val[i]) - mean_q;
			uc = (c < 0) ? -c : c;
			nm = longint'((uc << 24) / sd);
			if (c < 0) nm = -nm;
			r.val = clip32(add62(qmul(gamma_q, nm), beta_q));
			r.last = (i + 1 == n);
			expected_q.push_back(r);
		end
	endtask

	task automatic backprop_layer(int n);
		longint dxh[NODES];
		longint inv, p, dvar, dm1, dmean, dbeta, dgamma, dv2, c, v;
		norm_out_t r;
		dvar = 0;
		dm1 = 0;
		dbeta = 0;
		dgamma = 0;
		inv = longint'((64'd1 << 48) / std_dev_q());
		p = qmul(qmul(inv, inv), inv);
		for (int i = 0; i < n; i++) begin
			c = longint'(node_val[i]) - mean_q;
			dxh[i] = qmul(delta_val[i], gamma_q);
			dvar = add62(dvar, qmul(qmul(qmul(dxh[i], c), HALF_NEG), p));
			dm1 += -2 * c;
		end
		dmean = qmul(dm1, dvar / longint'(n));
		for (int i = 0; i < n; i++) dmean = add62(dmean, qmul(dxh[i], -inv));
		for (int i = 0; i < n; i++) begin
			c = longint'(node_val[i]) - mean_q;
			dbeta += delta_val[i];
			dgamma = add62(dgamma, qmul(qmul(delta_val[i], c), inv));
		end
		dv2 = clip62(2 * dvar);
		for (int i = 0; i < n; i++) begin
			c = longint'(node_val[i]) - mean_q;
			v = qmul(dxh[i], inv);
			v = add62(v, qmul(dv2, c) / longint'(n));
			v = add62(v, dmean / longint'(n));
			r.val = clip32(v);
			r.last = (i + 1 == n);
			expected_q.push_back(r);
		end
		beta_q = clip32(longint'(beta_q) - qmul(lrate_q, dbeta) / longint'(n));
		gamma_q = clip32(longint'(gamma_q) - qmul(lrate_q, dgamma) / longint'(n));
	endtask

	task automatic absorb_beat(beat_t b);
		int n;
		if (fill_idx < NODES) begin
			if (b.act == ACT_BWD) delta_val[fill_idx] = b.val;
			else node_val[fill_idx] = b.val;
			fill_idx++;
		end
		if (b.last) begin
			n = fill_idx;
			fill_idx = 0;
			if (b.act == ACT_BWD) backprop_layer(n);
			else normalize_layer(n);
		end
	endtask

	task automatic queue_beat(logic a, logic [31:0] v, logic l);
		beat_t b;
		b.act = a;
		b.val = v;
		b.last = l;
		beat_q.push_back(b);
		if (gen_idx < NODES) begin
			if (a == ACT_BWD) d_written[gen_idx] = 1;
			else x_written[gen_idx] = 1;
			gen_idx++;
		end
		if (l) gen_idx = 0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 1 << 27) - (1 << 26);
		endcase
	endfunction

	function automatic int stored_run();
		int k;
		k = 0;
		while (k < NODES && x_written[k]) k++;
		return k;
	endfunction

	// one vector, legal given what has been stored; returns beat count
	task automatic make_vector(output int len);
		int kind, cx, lim;
		logic a;
		cx = stored_run();
		kind = $urandom_range(0, 9);
		if (cx == 0 || (kind == 9 && cx < 2)) kind = 0;
		if (kind <= 3) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				a = (i >= NODES && i != len - 1) ? logic'($urandom_range(0, 1)) : ACT_FWD;
				queue_beat(a, pick_value(), i == len - 1);
			end
		end else if (kind <= 7) begin
			if (cx == NODES && $urandom_range(0, 5) == 0) len = $urandom_range(16, 20);
			else len = $urandom_range(1, (cx > 8) ? 8 : cx);
			for (int i = 0; i < len; i++) begin
				a = (i >= NODES && i != len - 1) ? logic'($urandom_range(0, 1)) : ACT_BWD;
				queue_beat(a, pick_value(), i == len - 1);
			end
		end else if (kind == 8) begin
			len = $urandom_range(2, 8);
			for (int i = 0; i < len; i++) begin
				a = (i < len - 1 && x_written[i] && $urandom_range(0, 1)) ? ACT_BWD : ACT_FWD;
				queue_beat(a, pick_value(), i == len - 1);
			end
		end else begin
			lim = (cx > 8) ? 8 : cx;
			len = $urandom_range(2, lim);
			for (int i = 0; i < len; i++) begin
				a = (i < len - 1 && d_written[i] && $urandom_range(0, 1)) ? ACT_FWD : ACT_BWD;
				queue_beat(a, pick_value(), i == len - 1);
			end
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (!(beat_q.size() == 0 && !s_tvalid && expected_q.size() == 0));
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_lrate(logic [LR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		lrate_q = v;
		lr_writes++;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL layer_norm_forward_backward");
			$finish;
		end
		if (arst_n && s_tvalid && s_tready) begin
			absorb_beat(cur_beat);
			beats_in++;
			beat_taken = 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result value=%h last=%b", $time, m_tdata, m_tlast);
			end else begin
				if (m_tdata !== expected_q[0].val) begin
					errors++;
					$display("%0t: value expected %h actual %h", $time,
						expected_q[0].val, m_tdata);
				end
				if (m_tlast !== expected_q[0].last) begin
					errors++;
					$display("%0t: last expected %b actual %b", $time,
						expected_q[0].last, m_tlast);
				end
				void'(expected_q.pop_front());
			end
		end
	end

	// source side
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || beat_taken)) begin
			beat_taken = 0;
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 0;
			end else if (beat_q.size() > 0) begin
				cur_beat = beat_q.pop_front();
				s_tdata <= cur_beat.val;
				s_tuser <= cur_beat.act;
				s_tlast <= cur_beat.last;
				s_tvalid <= 1;
				if (!no_idle) begin
					case ($urandom_range(0, 19))
						0: src_gap = $urandom_range(10, 40);
						1, 2, 3, 4: src_gap = $urandom_range(1, 3);
						default: src_gap = 0;
					endcase
				end
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// sink side
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1;
				sink_hold = 5000;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 0;
			end else if (no_idle) begin
				m_tready <= 1;
			end else begin
				case ($urandom_range(0, 19))
					0: sink_hold = $urandom_range(20, 200);
					1, 2, 3, 4: sink_hold = $urandom_range(1, 3);
					default: sink_hold = 0;
				endcase
				m_tready <= (sink_hold == 0);
			end
		end
	end

	initial begin
		int len, got;
		logic [LR_W-1:0] rates[6];
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = ACT_FWD;
		s_tlast = 0;
		m_tready = 0;
		fill_idx = 0;
		mean_q = 0;
		var_q = 0;
		beta_q = 0;
		gamma_q = Q_ONE;
		lrate_q = LR_RESET;
		gen_idx = 0;
		errors = 0;
		cycles = 0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, single node, backward, mixed vectors
		queue_beat(ACT_FWD, 32'h7FFF_FFFF, 0);
		queue_beat(ACT_FWD, 32'h8000_0000, 0);
		queue_beat(ACT_FWD, 32'h0000_0000, 0);
		queue_beat(ACT_FWD, 32'h0000_0001, 1);
		queue_beat(ACT_FWD, 32'h0100_0000, 1);
		queue_beat(ACT_FWD, 32'hFF80_0000, 0);
		queue_beat(ACT_FWD, 32'h0040_0000, 0);
		queue_beat(ACT_FWD, 32'h0200_0000, 1);
		queue_beat(ACT_BWD, 32'h7FFF_FFFF, 0);
		queue_beat(ACT_BWD, 32'h8000_0000, 0);
		queue_beat(ACT_BWD, 32'h0010_0000, 1);
		queue_beat(ACT_FWD, 32'h0300_0000, 0);
		queue_beat(ACT_BWD, 32'hFFF0_0000, 0);
		queue_beat(ACT_FWD, 32'hFD00_0000, 1);
		queue_beat(ACT_BWD, 32'h0008_0000, 0);
		queue_beat(ACT_FWD, 32'h0123_4567, 0);
		queue_beat(ACT_BWD, 32'hFFFE_0000, 1);
		wait_idle();

		rates[0] = '0;
		rates[1] = 25'd16777216;
		rates[2] = 25'd1;
		rates[3] = $urandom_range(0, 16777216);
		rates[4] = $urandom_range(0, 16777216);
		rates[5] = LR_RESET;
		for (int ph = 0; ph < 6; ph++) begin
			write_lrate(rates[ph]);
			no_idle = (ph == 2);
			got = 0;
			while (got < 57) begin
				make_vector(len);
				got += len;
			end
			wait_idle();
		end
		no_idle = 0;

		$display("covered %0d input beats and %0d checked results", beats_in, results_seen);
		$display("over %0d learning-rate settings incl. 0 and 1.0", lr_writes);
		if (errors == 0) begin
			$display("PASS layer_norm_forward_backward");
		end else begin
			$display("FAIL layer_norm_forward_backward");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: sim.f
sv/lnfb_pkg.sv
sv/lnfb_arith.sv
sv/layer_norm_forward_backward.sv
tb/testbench.sv
